[src/tx_byte_buffer_autoflush_top_defines.svh]
// assertion macros for the transmit byte buffer
// no dependencies; expects clk and rst_n in the scope of each use
`ifndef TX_BYTE_BUFFER_AUTOFLUSH_TOP_DEFINES_SVH
`define TX_BYTE_BUFFER_AUTOFLUSH_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define TBAF_ASSERT_IMPL(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define TBAF_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define TBAF_ASSERT_IMPL(name, ante, cons, msg)
`define TBAF_ASSERT_NEXT(name, ante, cons, msg)
`endif
`endif

[src/tbaf_pkg.sv]
// shared codes, defaults and control structs of the transmit byte buffer
// no dependencies
package tbaf_pkg;

    localparam int DEPTH_DEF = 32;

    localparam logic [1:0] OP_PUT      = 2'd0;
    localparam logic [1:0] OP_SEND     = 2'd1;
    localparam logic [1:0] OP_SEND_ALL = 2'd2;
    localparam logic [1:0] OP_PUT_SEND = 2'd3;

    localparam logic [1:0] ACT_HOLD   = 2'd0;
    localparam logic [1:0] ACT_FLUSH  = 2'd1;
    localparam logic [1:0] ACT_REPORT = 2'd2;
    localparam logic [1:0] ACT_RESET  = ACT_FLUSH;

    localparam logic [1:0] KIND_SINGLE = 2'd0;
    localparam logic [1:0] KIND_FLUSH  = 2'd1;
    localparam logic [1:0] KIND_REPORT = 2'd2;

    // controller to datapath
    typedef struct packed {
        logic accept;
        logic ld_run;
        logic ld_send;
        logic sel_send;
    } ctl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic run_go;
        logic send_go;
        logic run_last;
        logic send_pend;
        logic out_free;
    } ctl_sts_t;

endpackage

[src/tbaf_if.sv]
// request and result channel interfaces of the transmit byte buffer
// no dependencies
interface tbaf_cmd_if;
    logic       valid;
    logic       ready;
    logic [1:0] op;
    logic [7:0] data_byte;

    modport source (output valid, output op, output data_byte, input ready);
    modport sink (input valid, input op, input data_byte, output ready);
endinterface

interface tbaf_rsp_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       out_valid;
    logic [1:0] out_kind;
    logic       out_last;
    logic       now_empty;
    logic       now_full;

    modport source (output valid, output out_byte, output out_valid, output out_kind,
                    output out_last, output now_empty, output now_full, input ready);
    modport sink (input valid, input out_byte, input out_valid, input out_kind,
                  input out_last, input now_empty, input now_full, output ready);
endinterface

[src/tbaf_ctrl.sv]
// sequencer of the transmit byte buffer: accepts requests, paces result runs
// depends on tbaf_pkg
module tbaf_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  tbaf_pkg::ctl_sts_t sts,
    output tbaf_pkg::ctl_cmd_t cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_RUN_FETCH,
        S_RUN_EMIT,
        S_SEND_FETCH,
        S_SEND_EMIT
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next   = state_reg;
        cmd.accept   = 1'b0;
        cmd.ld_run   = 1'b0;
        cmd.ld_send  = 1'b0;
        cmd.sel_send = (state_reg == S_SEND_FETCH) || (state_reg == S_SEND_EMIT);
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    if (sts.run_go)
                    begin
                        state_next = S_RUN_FETCH;
                    end
                    else if (sts.send_go)
                    begin
                        state_next = S_SEND_FETCH;
                    end
                end
            end
            S_RUN_FETCH:
            begin
                state_next = S_RUN_EMIT;
            end
            S_RUN_EMIT:
            begin
                if (sts.out_free)
                begin
                    cmd.ld_run = 1'b1;
                    if (!sts.run_last)
                    begin
                        state_next = S_RUN_FETCH;
                    end
                    else if (sts.send_pend)
                    begin
                        state_next = S_SEND_FETCH;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_SEND_FETCH:
            begin
                state_next = S_SEND_EMIT;
            end
            S_SEND_EMIT:
            begin
                if (sts.out_free)
                begin
                    cmd.ld_send = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

[src/tbaf_dpath.sv]
// datapath of the transmit byte buffer: positions, byte store, result register
// depends on tbaf_pkg and tx_byte_buffer_autoflush_top_defines.svh
`include "tx_byte_buffer_autoflush_top_defines.svh"
module tbaf_dpath #(
    parameter int DEPTH = tbaf_pkg::DEPTH_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_wr_en,
    input  logic [1:0]         cfg_wr_data,
    input  logic [1:0]         op,
    input  logic [7:0]         data_byte,
    input  tbaf_pkg::ctl_cmd_t cmd,
    output tbaf_pkg::ctl_sts_t sts,
    output logic               rsp_valid,
    input  logic               rsp_ready,
    output logic [7:0]         out_byte,
    output logic               out_valid,
    output logic [1:0]         out_kind,
    output logic               out_last,
    output logic               now_empty,
    output logic               now_full
);

    localparam int PW = $clog2(DEPTH + 1);
    localparam int AW = $clog2(DEPTH);
    localparam logic [PW-1:0] DEPTH_P = PW'(DEPTH);

    logic [7:0] mem [DEPTH];
    logic [7:0] rd_data_reg;
    logic [AW-1:0] rd_addr;

    logic [1:0]    full_action_reg;
    logic [PW-1:0] wp_reg;
    logic [PW-1:0] rp_reg;
    logic          ff_reg;

    // latched request context
    logic [PW-1:0] run_idx_reg;
    logic [PW-1:0] run_end_reg;
    logic [1:0]    run_kind_reg;
    logic          send_pend_reg;
    logic          send_ok_reg;
    logic [AW-1:0] send_addr_reg;
    logic          fin_empty_reg;
    logic          fin_full_reg;

    logic          rsp_valid_reg;
    logic [7:0]    out_byte_reg;
    logic          out_valid_reg;
    logic [1:0]    out_kind_reg;
    logic          out_last_reg;
    logic          now_empty_reg;
    logic          now_full_reg;

    // request decode and position update
    logic          is_put;
    logic          send_go;
    logic          run_go;
    logic          put_run;
    logic          all_run;
    logic          clr_after;
    logic          send_ok;
    logic          run_last;
    logic          out_free;
    logic          ffb;
    logic          ffc;
    logic          fff;
    logic [1:0]    run_kind_next;
    logic [PW-1:0] wpa;
    logic [PW-1:0] rpa;
    logic [PW-1:0] wpb;
    logic [PW-1:0] wpc;
    logic [PW-1:0] rpc;
    logic [PW-1:0] rpd;
    logic [PW-1:0] wpf;
    logic [PW-1:0] rpf;

    always_comb
    begin
        is_put = (op == tbaf_pkg::OP_PUT) || (op == tbaf_pkg::OP_PUT_SEND);
        send_go = (op == tbaf_pkg::OP_SEND) || (op == tbaf_pkg::OP_PUT_SEND);
        // a put into a full buffer discards everything first
        wpa = (is_put && ff_reg) ? '0 : wp_reg;
        rpa = (is_put && ff_reg) ? '0 : rp_reg;
        wpb = is_put ? wpa + PW'(1) : wpa;
        ffb = is_put ? (wpb == DEPTH_P) : ff_reg;
        put_run = is_put && ffb &&
                  ((full_action_reg == tbaf_pkg::ACT_FLUSH) ||
                   (full_action_reg == tbaf_pkg::ACT_REPORT));
        all_run = (op == tbaf_pkg::OP_SEND_ALL) && (rp_reg < wp_reg);
        run_go = put_run || all_run;
        run_kind_next = (is_put && (full_action_reg == tbaf_pkg::ACT_REPORT)) ?
                        tbaf_pkg::KIND_REPORT : tbaf_pkg::KIND_FLUSH;
        clr_after = (put_run && (full_action_reg == tbaf_pkg::ACT_FLUSH)) ||
                    (op == tbaf_pkg::OP_SEND_ALL);
        wpc = clr_after ? '0 : wpb;
        rpc = clr_after ? '0 : rpa;
        ffc = clr_after ? 1'b0 : ffb;
        send_ok = rpc < wpc;
        rpd = rpc + PW'(1);
        wpf = wpc;
        rpf = rpc;
        fff = ffc;
        if (send_go)
        begin
            if (send_ok && (rpd != wpc))
            begin
                rpf = rpd;
            end
            else
            begin
                wpf = '0;
                rpf = '0;
                fff = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            full_action_reg <= tbaf_pkg::ACT_RESET;
            wp_reg          <= '0;
            rp_reg          <= '0;
            ff_reg          <= 1'b0;
            run_idx_reg     <= '0;
            run_end_reg     <= '0;
            run_kind_reg    <= tbaf_pkg::KIND_FLUSH;
            send_pend_reg   <= 1'b0;
            send_ok_reg     <= 1'b0;
            send_addr_reg   <= '0;
            fin_empty_reg   <= 1'b1;
            fin_full_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                full_action_reg <= cfg_wr_data;
            end
            if (cmd.accept)
            begin
                wp_reg        <= wpf;
                rp_reg        <= rpf;
                ff_reg        <= fff;
                run_idx_reg   <= rpa;
                run_end_reg   <= wpb;
                run_kind_reg  <= run_kind_next;
                send_pend_reg <= send_go;
                send_ok_reg   <= send_ok;
                send_addr_reg <= rpc[AW-1:0];
                fin_empty_reg <= (rpf == wpf);
                fin_full_reg  <= fff;
            end
            else if (cmd.ld_run)
            begin
                run_idx_reg <= run_idx_reg + PW'(1);
            end
        end
    end

    // byte store, registered read
    assign rd_addr = cmd.sel_send ? send_addr_reg : run_idx_reg[AW-1:0];

    always_ff @(posedge clk)
    begin
        if (cmd.accept && is_put)
        begin
            mem[wpa[AW-1:0]] <= data_byte;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign run_last = (run_idx_reg + PW'(1)) == run_end_reg;
    assign out_free = !rsp_valid_reg || rsp_ready;

    assign sts = '{
        run_go:    run_go,
        send_go:   send_go,
        run_last:  run_last,
        send_pend: send_pend_reg,
        out_free:  out_free
    };

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (cmd.ld_run || cmd.ld_send)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    // end-of-request flags travel with each result so a new request cannot change them
    always_ff @(posedge clk)
    begin
        if (cmd.ld_run)
        begin
            out_byte_reg  <= rd_data_reg;
            out_valid_reg <= 1'b1;
            out_kind_reg  <= run_kind_reg;
            out_last_reg  <= run_last && !send_pend_reg;
            now_empty_reg <= fin_empty_reg;
            now_full_reg  <= fin_full_reg;
        end
        else if (cmd.ld_send)
        begin
            out_byte_reg  <= send_ok_reg ? rd_data_reg : 8'd0;
            out_valid_reg <= send_ok_reg;
            out_kind_reg  <= tbaf_pkg::KIND_SINGLE;
            out_last_reg  <= 1'b1;
            now_empty_reg <= fin_empty_reg;
            now_full_reg  <= fin_full_reg;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign out_byte  = out_byte_reg;
    assign out_valid = out_valid_reg;
    assign out_kind  = out_kind_reg;
    assign out_last  = out_last_reg;
    assign now_empty = now_empty_reg;
    assign now_full  = now_full_reg;

    `TBAF_ASSERT_IMPL(a_no_overwrite, cmd.ld_run || cmd.ld_send, out_free, "overwrite")
    `TBAF_ASSERT_NEXT(a_load_shows, cmd.ld_run || cmd.ld_send, rsp_valid_reg, "result not shown")
    `TBAF_ASSERT_IMPL(a_full_at_end, ff_reg, wp_reg == DEPTH_P, "full flag away from end")
    `TBAF_ASSERT_IMPL(a_rp_le_wp, 1'b1, rp_reg <= wp_reg, "read position past write position")
    `TBAF_ASSERT_IMPL(a_empty_zero, rp_reg == wp_reg, wp_reg == '0, "empty buffer not rewound")

endmodule

[src/tx_byte_buffer_autoflush_top.sv]
// top level of the transmit byte buffer with action on full
// depends on tbaf_pkg, tbaf_if, tbaf_ctrl and tbaf_dpath
// sequence: a put with no result leaves the sequencer idle; a single send has its result
//   valid once send emit loads it, and the next request goes in after that, back in idle
// per byte: a registered store read (fetch) and then a load into the result register
//   (emit), which waits while it is full; input is held through the run and trailing send
// reset: positions and full flag cleared, full_action set to flush; store not cleared
module tx_byte_buffer_autoflush_top #(
    parameter int DEPTH = tbaf_pkg::DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_wr_data,
    tbaf_cmd_if.sink    cmd,
    tbaf_rsp_if.source  rsp
);

    // command and status between sequencer and datapath
    tbaf_pkg::ctl_cmd_t ctl_cmd;
    tbaf_pkg::ctl_sts_t ctl_sts;

    // sequencer: takes a request only when idle, then walks the result run
    // (fetch a byte, then load it into the result register when it is free)
    tbaf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (cmd.valid),
        .in_ready (cmd.ready),
        .sts      (ctl_sts),
        .cmd      (ctl_cmd)
    );

    // datapath: positions are updated to the end-of-request value when the
    // request is taken; the run bounds and the pending send are latched so the
    // results stream out afterwards, all carrying the final empty/full flags
    tbaf_dpath #(
        .DEPTH (DEPTH)
    ) u_dpath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .op          (cmd.op),
        .data_byte   (cmd.data_byte),
        .cmd         (ctl_cmd),
        .sts         (ctl_sts),
        .rsp_valid   (rsp.valid),
        .rsp_ready   (rsp.ready),
        .out_byte    (rsp.out_byte),
        .out_valid   (rsp.out_valid),
        .out_kind    (rsp.out_kind),
        .out_last    (rsp.out_last),
        .now_empty   (rsp.now_empty),
        .now_full    (rsp.now_full)
    );

endmodule
